@@ sv/tim_pkg.sv @@
package tim_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INSERT,
      ST_LOOK,
      ST_CHECK,
      ST_SWEEP,
      ST_RESP
   } state_type;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_FIND   = 2'd1;
   localparam logic [1:0] KIND_ERASE  = 2'd2;
   localparam logic [1:0] KIND_SWEEP  = 2'd3;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_RANGE    = 3'd1;
   localparam logic [2:0] STATUS_UNUSED   = 3'd2;
   localparam logic [2:0] STATUS_EXPIRED  = 3'd3;
   localparam logic [2:0] STATUS_FULL     = 3'd4;

   localparam logic [12:0] COUNT_MAX = 13'd8191;
   localparam logic [15:0] TIMEOUT_RESET = 16'd5;

   typedef struct packed {
      logic        used;
      logic [31:0] stamp;
      logic [15:0] port;
      logic [31:0] ip;
      logic [15:0] query_id;
   } slot_type;

endpackage

@@ sv/transaction_id_map.sv @@
// Relayed transaction ID table with timeout.
// Request channel (req_valid/req_ready) carries one operation per beat:
// insert, find, erase or sweep. Response channel (rsp_valid/rsp_ready) returns
// exactly one beat per request. The block handles one request at a time and
// drops req_ready from acceptance until the response beat is taken.
// Steps per request, all through one single-port-read / single-port-write slot
// memory:
//   find, erase : read, check/write, response; the check is skipped when out of range
//   insert      : scans slots from the shard cursor until a free or expired slot
//                 is found, or SLOTS_PER_SHARD slots when the shard is full
//   sweep       : SHARD_COUNT*SLOTS_PER_SHARD slots, one slot per cycle
// The response holds in its register while rsp_ready is low; no new request
// is taken until it is delivered.
// After reset a clearing pass walks the memory one slot per cycle, marking
// every slot free and zeroing the shard cursors, with req_ready low.
// csr_wr_en writes the timeout at any time; the timeout resets to 5 seconds.
module transaction_id_map
   import tim_pkg::*;
#(
   parameter int SHARD_COUNT     = 4,
   parameter int SLOTS_PER_SHARD = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_entry_id,
   input  logic [15:0] req_query_id,
   input  logic [31:0] req_client_ip,
   input  logic [15:0] req_client_port,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_new_id,
   output logic [15:0] rsp_found_query_id,
   output logic [31:0] rsp_found_ip,
   output logic [15:0] rsp_found_port,
   output logic [12:0] rsp_released_count,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int TABLE = SHARD_COUNT * SLOTS_PER_SHARD;
   localparam int IDX_W = $clog2(TABLE);
   localparam int SH_W  = (SHARD_COUNT > 1) ? $clog2(SHARD_COUNT) : 1;
   localparam int SL_W  = $clog2(SLOTS_PER_SHARD);
   localparam int CNT_W = IDX_W + 1;

   state_type state_ff, state_in;

   logic [15:0]      timeout_ff;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [1:0]       kind_ff;
   logic [15:0]      entry_ff, qid_ff, port_ff;
   logic [31:0]      ip_ff, now_ff;
   logic [SH_W-1:0]  pick_ff, pick_in, shard_ff, shard_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SL_W-1:0]  slot_ff, slot_in, pend_slot_ff, pend_slot_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_addr_ff, pend_addr_in;
   logic [12:0]      rel_ff, rel_in;

   logic [2:0]  status_ff, status_in;
   logic [15:0] new_id_ff, new_id_in, fq_ff, fq_in, fport_ff, fport_in;
   logic [31:0] fip_ff, fip_in;

   slot_type         mem [TABLE];
   slot_type         rd_q_ff, mem_wdata;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr, rd_addr;

   logic [SL_W-1:0]  cursor_mem [SHARD_COUNT];
   logic [SL_W-1:0]  cursor_q_ff, cur_wdata;
   logic             cur_we;
   logic [SH_W-1:0]  cur_waddr;

   logic             expired, accept;
   logic [31:0]      age, entry32, clr32, pend32;
   logic [SL_W-1:0]  cur_slot, cur_slot_next;
   logic [IDX_W-1:0] scan_addr;
   logic [12:0]      rel_sat;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cursor_mem[cur_waddr] <= cur_wdata;
      end
      cursor_q_ff <= cursor_mem[pick_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         timeout_ff <= TIMEOUT_RESET;
         clr_ff     <= '0;
         pick_ff    <= '0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pick_ff  <= pick_in;
         pend_ff  <= pend_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         entry_ff <= req_entry_id;
         qid_ff   <= req_query_id;
         ip_ff    <= req_client_ip;
         port_ff  <= req_client_port;
         now_ff   <= req_now;
      end
      shard_ff     <= shard_in;
      cnt_ff       <= cnt_in;
      slot_ff      <= slot_in;
      pend_slot_ff <= pend_slot_in;
      pend_addr_ff <= pend_addr_in;
      rel_ff       <= rel_in;
      status_ff    <= status_in;
      new_id_ff    <= new_id_in;
      fq_ff        <= fq_in;
      fip_ff       <= fip_in;
      fport_ff     <= fport_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_RESP);

   assign rsp_status         = status_ff;
   assign rsp_new_id         = new_id_ff;
   assign rsp_found_query_id = fq_ff;
   assign rsp_found_ip       = fip_ff;
   assign rsp_found_port     = fport_ff;
   assign rsp_released_count = rel_ff;

   assign age     = now_ff - rd_q_ff.stamp;
   assign expired = age > {16'd0, timeout_ff};
   assign entry32 = 32'(entry_ff);
   assign clr32   = 32'(clr_ff);
   assign pend32  = 32'(pend_addr_ff);
   assign rel_sat = (rel_ff == COUNT_MAX) ? rel_ff : rel_ff + 13'd1;

   // the first scan slot comes from the shard cursor, later ones from the walker
   assign cur_slot      = (cnt_ff == '0) ? cursor_q_ff : slot_ff;
   assign cur_slot_next = (cur_slot == SL_W'(SLOTS_PER_SHARD - 1)) ? '0 : cur_slot + 1'b1;
   assign scan_addr     = IDX_W'(IDX_W'(shard_ff) * IDX_W'(SLOTS_PER_SHARD) + IDX_W'(cur_slot));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pick_in      = pick_ff;
      shard_in     = shard_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      pend_addr_in = pend_addr_ff;
      rel_in       = rel_ff;
      status_in    = status_ff;
      new_id_in    = new_id_ff;
      fq_in        = fq_ff;
      fip_in       = fip_ff;
      fport_in     = fport_ff;
      mem_we       = 1'b0;
      mem_waddr    = pend_addr_ff;
      mem_wdata    = rd_q_ff;
      rd_addr      = '0;
      cur_we       = 1'b0;
      cur_waddr    = shard_ff;
      cur_wdata    = (pend_slot_ff == SL_W'(SLOTS_PER_SHARD - 1)) ? '0 : pend_slot_ff + 1'b1;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            if (clr32 < 32'(SHARD_COUNT)) begin
               cur_we    = 1'b1;
               cur_waddr = SH_W'(clr_ff);
               cur_wdata = '0;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(TABLE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               status_in = STATUS_OK;
               new_id_in = '0;
               fq_in     = '0;
               fip_in    = '0;
               fport_in  = '0;
               rel_in    = '0;
               cnt_in    = '0;
               pend_in   = 1'b0;
               unique case (req_kind) inside
                  KIND_INSERT: begin
                     shard_in = pick_ff;
                     pick_in  = (pick_ff == SH_W'(SHARD_COUNT - 1)) ? '0 : pick_ff + 1'b1;
                     state_in = ST_INSERT;
                  end
                  KIND_FIND, KIND_ERASE: state_in = ST_LOOK;
                  KIND_SWEEP: state_in = ST_SWEEP;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_INSERT: begin
            if (pend_ff && (!rd_q_ff.used || expired)) begin
               mem_we    = 1'b1;
               mem_wdata = '{used: 1'b1, stamp: now_ff, port: port_ff, ip: ip_ff,
                             query_id: qid_ff};
               cur_we    = 1'b1;
               new_id_in = pend32[15:0];
               pend_in   = 1'b0;
               state_in  = ST_RESP;
            end else if (cnt_ff == CNT_W'(SLOTS_PER_SHARD)) begin
               status_in = STATUS_FULL;
               pend_in   = 1'b0;
               state_in  = ST_RESP;
            end else begin
               rd_addr      = scan_addr;
               pend_in      = 1'b1;
               pend_addr_in = scan_addr;
               pend_slot_in = cur_slot;
               slot_in      = cur_slot_next;
               cnt_in       = cnt_ff + 1'b1;
            end
         end
         ST_LOOK: begin
            rd_addr = entry32[IDX_W-1:0];
            pend_addr_in = entry32[IDX_W-1:0];
            if (entry32 >= 32'(TABLE)) begin
               status_in = STATUS_RANGE;
               state_in  = ST_RESP;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_RESP;
            if (!rd_q_ff.used) begin
               status_in = STATUS_UNUSED;
            end else if (kind_ff == KIND_ERASE) begin
               mem_we         = 1'b1;
               mem_wdata.used = 1'b0;
            end else if (expired) begin
               status_in = STATUS_EXPIRED;
            end else begin
               fq_in    = rd_q_ff.query_id;
               fip_in   = rd_q_ff.ip;
               fport_in = rd_q_ff.port;
            end
         end
         ST_SWEEP: begin
            // free the slot read last cycle while the next read is under way
            if (pend_ff && rd_q_ff.used && expired) begin
               mem_we         = 1'b1;
               mem_wdata.used = 1'b0;
               rel_in         = rel_sat;
            end
            if (cnt_ff == CNT_W'(TABLE)) begin
               pend_in  = 1'b0;
               state_in = ST_RESP;
            end else begin
               rd_addr      = cnt_ff[IDX_W-1:0];
               pend_in      = 1'b1;
               pend_addr_in = cnt_ff[IDX_W-1:0];
               cnt_in       = cnt_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while response pending");

   a_full_no_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |-> (rsp_new_id == 16'd0))
      else $error("full table returned an ID");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("idle after accept");

   a_clear_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid) else $error("response during clear");

endmodule
